// File: rtl/sorted_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Shared property wrappers clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define STQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted timer queue check failed");

// next-cycle implication
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted timer queue check failed");

`endif

// File: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Item types, codes and default sizes shared by the queue cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int TIME_W          = 64;
    localparam int CFG_W           = 5;

    localparam logic [CFG_W-1:0] SERVICE_RESET = 5'd10;
    localparam logic [CFG_W-1:0] SERVICE_CAP   = 5'd16;
    localparam logic [CFG_W-1:0] SERVICE_MIN   = 5'd1;

    typedef enum logic [1:0] {
        K_ADD     = 2'd0,
        K_TICK    = 2'd1,
        K_SERVICE = 2'd2,
        K_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_FULL    = 2'd1,
        ST_EXPIRED = 2'd2,
        ST_IDLE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  timer_id;
        logic [31:0] delay;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] expired_id;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_SVC  = 3'b100
    } t_state;

endpackage

`default_nettype wire

// File: rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// One queue slot: compares its expiry with the key and shifts with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cell #(
    parameter int ID_BITS = stq_pkg::ID_BITS_DEF
) (
    input  logic                      i_clk,
    input  stq_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_occ,
    input  logic [stq_pkg::TIME_W-1:0] i_key,
    input  logic [ID_BITS-1:0]        i_new_hdl,
    input  logic                      i_prev_go,
    input  logic [stq_pkg::TIME_W-1:0] i_prev_exp,
    input  logic [ID_BITS-1:0]        i_prev_hdl,
    input  logic [stq_pkg::TIME_W-1:0] i_next_exp,
    input  logic [ID_BITS-1:0]        i_next_hdl,
    output logic                      o_go,
    output logic                      o_le,
    output logic [stq_pkg::TIME_W-1:0] o_exp,
    output logic [ID_BITS-1:0]        o_hdl
);
    import stq_pkg::*;

    logic [TIME_W-1:0]  r_exp, n_exp;
    logic [ID_BITS-1:0] r_hdl, n_hdl;

    assign o_go  = i_occ && (r_exp < i_key);
    assign o_le  = r_exp <= i_key;
    assign o_exp = r_exp;
    assign o_hdl = r_hdl;

    always_comb begin
        n_exp = r_exp;
        n_hdl = r_hdl;
        if (i_ctl.ins && !o_go) begin
            if (i_prev_go) begin
                n_exp = i_key;
                n_hdl = i_new_hdl;
            end else begin
                n_exp = i_prev_exp;
                n_hdl = i_prev_hdl;
            end
        end else if (i_ctl.pop) begin
            n_exp = i_next_exp;
            n_hdl = i_next_hdl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_hdl <= n_hdl;
    end

endmodule

`default_nettype wire

// File: rtl/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted timer queue
// Pending timers held in a row of shift cells, ordered by expiry tick.
// ----------------------------------------------------------------------------
// Add: expiry sum is registered on start, then parallel insert in S_INS.
// Tick, full add, unused kind: one result, registered directly from idle.
// Service: one result per due timer up to the limit, one head pop per cycle.
// Results are strobed for one cycle; busy is high while an item is in work.
// Reset (synchronous): queue empty, time zero, service limit 10.
`default_nettype none
`include "sorted_timer_queue_assert.svh"

module sorted_timer_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = stq_pkg::ID_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  stq_pkg::t_in_item        i_item,
    output logic                     o_res_valid,
    output stq_pkg::t_out_item       o_res,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [stq_pkg::CFG_W-1:0] i_cfg_data
);
    import stq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [CFG_W-1:0]   r_cfg;
    logic [CFG_W-1:0]   r_left, n_left;
    logic [TIME_W-1:0]  r_key, n_key;
    logic [ID_BITS-1:0] r_id, n_id;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic                     accept;
    logic [CFG_W-1:0]         limit;
    logic [TIME_W:0]          sum;
    logic [ID_BITS+7:0]       in_ext;
    logic [ID_BITS+7:0]       head_ext;
    logic [TIME_W-1:0]        cell_key;
    t_cell_ctl                ctl;
    logic                     head_exp;
    logic                     next_exp;

    logic [QUEUE_DEPTH-1:0]   occ;
    logic [QUEUE_DEPTH-1:0]   go;
    logic [QUEUE_DEPTH-1:0]   le;
    logic [TIME_W-1:0]        exp_q [QUEUE_DEPTH];
    logic [ID_BITS-1:0]       hdl_q [QUEUE_DEPTH];

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign sum      = {1'b0, r_time} + {{(TIME_W - 32 + 1){1'b0}}, i_item.delay};
    assign in_ext   = {{ID_BITS{1'b0}}, i_item.timer_id};
    assign head_ext = {8'b0, hdl_q[0]};
    assign cell_key = (r_state == S_SVC) ? r_time : r_key;
    assign head_exp = occ[0] && le[0];
    assign next_exp = occ[1] && le[1];
    assign ctl.ins  = (r_state == S_INS);
    assign ctl.pop  = (r_state == S_SVC) && head_exp;

    always_comb begin
        if (r_cfg == '0) begin
            limit = SERVICE_MIN;
        end else if (r_cfg > SERVICE_CAP) begin
            limit = SERVICE_CAP;
        end else begin
            limit = r_cfg;
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic               prev_go;
        logic [TIME_W-1:0]  prev_exp;
        logic [ID_BITS-1:0] prev_hdl;
        logic [TIME_W-1:0]  next_exp_v;
        logic [ID_BITS-1:0] next_hdl_v;

        assign occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign prev_go  = 1'b1;
            assign prev_exp = r_key;
            assign prev_hdl = r_id;
        end else begin : g_body
            assign prev_go  = go[g-1];
            assign prev_exp = exp_q[g-1];
            assign prev_hdl = hdl_q[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_exp_v = exp_q[g];
            assign next_hdl_v = hdl_q[g];
        end else begin : g_mid
            assign next_exp_v = exp_q[g+1];
            assign next_hdl_v = hdl_q[g+1];
        end

        stq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_occ      (occ[g]),
            .i_key      (cell_key),
            .i_new_hdl  (r_id),
            .i_prev_go  (prev_go),
            .i_prev_exp (prev_exp),
            .i_prev_hdl (prev_hdl),
            .i_next_exp (next_exp_v),
            .i_next_hdl (next_hdl_v),
            .o_go       (go[g]),
            .o_le       (le[g]),
            .o_exp      (exp_q[g]),
            .o_hdl      (hdl_q[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_time      = r_time;
        n_left      = r_left;
        n_key       = r_key;
        n_id        = r_id;
        n_out_valid = 1'b0;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.expired_id = 8'd0;
                    n_out.last       = 1'b1;
                    case (i_item.kind)
                        K_ADD: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_FULL;
                            end else begin
                                n_key   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                                n_id    = in_ext[ID_BITS-1:0];
                                n_state = S_INS;
                            end
                        end
                        K_TICK: begin
                            if (r_time != '1) begin
                                n_time = r_time + TIME_W'(1);
                            end
                            n_out_valid  = 1'b1;
                            n_out.status = ST_IDLE;
                        end
                        K_SERVICE: begin
                            n_left  = limit;
                            n_state = S_SVC;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out.status = ST_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                n_count          = r_count + CNT_W'(1);
                n_out_valid      = 1'b1;
                n_out.status     = ST_ADDED;
                n_out.expired_id = 8'd0;
                n_out.last       = 1'b1;
                n_state          = S_IDLE;
            end
            S_SVC: begin
                n_out_valid = 1'b1;
                if (head_exp) begin
                    n_count          = r_count - CNT_W'(1);
                    n_left           = r_left - CFG_W'(1);
                    n_out.status     = ST_EXPIRED;
                    n_out.expired_id = head_ext[7:0];
                    n_out.last       = (r_left == CFG_W'(1)) || !next_exp;
                    if (n_out.last) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_out.status     = ST_IDLE;
                    n_out.expired_id = 8'd0;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_time      <= '0;
            r_cfg       <= SERVICE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_key  <= n_key;
        r_id   <= n_id;
        r_out  <= n_out;
    end

    `STQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `STQ_ASSERT_NEXT(a_pop_count, (r_state == S_SVC) && head_exp, r_count == $past(r_count) - CNT_W'(1))
    `STQ_ASSERT_NEXT(a_insert_done, r_state == S_INS, o_res_valid && o_res.last && !busy)
    `STQ_ASSERT_NEXT(a_time_mono, 1'b1, r_time >= $past(r_time))

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives add, tick, service and unused items through the command port and
// checks every result strobe against an in-bench model of the expiry-sorted
// queue. The service limit is rewritten between phases, including the
// out-of-range values. Sender gaps vary by phase. A stall watchdog ends the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import stq_pkg::*;

    localparam int SLOTS       = QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 24;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in_item            i_item;
    logic                o_res_valid;
    t_out_item           o_res;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data;

    logic [63:0]         tick_now;
    logic [63:0]         slot_expiry [SLOTS];
    logic [7:0]          slot_id [SLOTS];
    int                  slot_count;
    logic [CFG_W-1:0]    service_limit;
    t_out_item           expected_results [$];

    int                  error_count;
    int                  sender_idle_pct;
    int                  stall_cycles;

    always #4 i_clk = ~i_clk;

    sorted_timer_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic t_in_item make_item(logic [1:0] kind, logic [7:0] id, logic [31:0] dly);
        t_in_item it;
        it.kind     = kind;
        it.timer_id = id;
        it.delay    = dly;
        return it;
    endfunction

    function automatic t_out_item make_result(logic [1:0] st, logic [7:0] id, logic lst);
        t_out_item r;
        r.status     = st;
        r.expired_id = id;
        r.last       = lst;
        return r;
    endfunction

    task automatic predict_timer_results(input t_in_item it);
        logic [64:0] sum;
        logic [63:0] due;
        int          pos;
        int          i;
        int          lim;
        int          due_count;
        begin
            case (it.kind)
                K_ADD: begin
                    if (slot_count >= SLOTS) begin
                        expected_results.push_back(make_result(ST_FULL, 8'd0, 1'b1));
                    end else begin
                        sum = {1'b0, tick_now} + {33'd0, it.delay};
                        due = sum[64] ? {64{1'b1}} : sum[63:0];
                        pos = 0;
                        while (pos < slot_count && slot_expiry[pos] < due)
                            pos++;
                        for (i = slot_count; i > pos; i--) begin
                            slot_expiry[i] = slot_expiry[i-1];
                            slot_id[i]     = slot_id[i-1];
                        end
                        slot_expiry[pos] = due;
                        slot_id[pos]     = it.timer_id;
                        slot_count++;
                        expected_results.push_back(make_result(ST_ADDED, 8'd0, 1'b1));
                    end
                end
                K_TICK: begin
                    if (tick_now != {64{1'b1}})
                        tick_now = tick_now + 64'd1;
                    expected_results.push_back(make_result(ST_IDLE, 8'd0, 1'b1));
                end
                K_SERVICE: begin
                    lim = service_limit;
                    if (lim < SERVICE_MIN)
                        lim = SERVICE_MIN;
                    if (lim > SERVICE_CAP)
                        lim = SERVICE_CAP;
                    due_count = 0;
                    while (due_count < lim && due_count < slot_count &&
                           slot_expiry[due_count] <= tick_now)
                        due_count++;
                    if (due_count == 0) begin
                        expected_results.push_back(make_result(ST_IDLE, 8'd0, 1'b1));
                    end else begin
                        for (i = 0; i < due_count; i++)
                            expected_results.push_back(
                                make_result(ST_EXPIRED, slot_id[i], i == due_count - 1));
                        for (i = due_count; i < slot_count; i++) begin
                            slot_expiry[i-due_count] = slot_expiry[i];
                            slot_id[i-due_count]     = slot_id[i];
                        end
                        slot_count -= due_count;
                    end
                end
                default: begin
                    expected_results.push_back(make_result(ST_IDLE, 8'd0, 1'b1));
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string msg);
        begin
            $display("mismatch: %s", msg);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_res_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d id %0h",
                                          o_res.status, o_res.expired_id));
            end else begin
                want = expected_results.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_res.status, want.status));
                if (o_res.expired_id !== want.expired_id)
                    report_mismatch($sformatf("expired_id got %0h expected %0h",
                                              o_res.expired_id, want.expired_id));
                if (o_res.last !== want.last)
                    report_mismatch($sformatf("last got %0b expected %0b",
                                              o_res.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input t_in_item it);
        begin
            @(negedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
            start  <= 1'b1;
            i_item <= it;
            @(posedge i_clk);
            while (busy)
                @(posedge i_clk);
            predict_timer_results(it);
        end
    endtask

    task automatic wait_idle();
        begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
            while (expected_results.size() != 0 || busy)
                @(posedge i_clk);
        end
    endtask

    task automatic write_service_limit(input logic [CFG_W-1:0] value);
        begin
            wait_idle();
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= value;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            service_limit = value;
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
        end
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        int       span;
        pick        = $urandom_range(99);
        it.timer_id = $urandom;
        it.delay    = $urandom;
        if (pick < 40) begin
            it.kind = K_ADD;
            span    = $urandom_range(99);
            if (span < 92)
                it.delay = $urandom_range(12);
            else if (span < 96)
                it.delay = $urandom_range(60, 13);
        end else if (pick < 70) begin
            it.kind = K_TICK;
        end else if (pick < 95) begin
            it.kind = K_SERVICE;
        end else begin
            it.kind = K_UNUSED;
        end
        return it;
    endfunction

    task automatic test_add_ordering();
        begin
            send_item(make_item(K_ADD, 8'h00, 32'd0));
            send_item(make_item(K_ADD, 8'hFF, 32'd1));
            send_item(make_item(K_ADD, 8'hA5, 32'd1));
            send_item(make_item(K_ADD, 8'h5A, 32'hFFFF_FFFF));
            send_item(make_item(K_ADD, 8'h3C, 32'd1));
            send_item(make_item(K_SERVICE, 8'h00, 32'd0));
            send_item(make_item(K_TICK, 8'h00, 32'd0));
            send_item(make_item(K_SERVICE, 8'h00, 32'd0));
            send_item(make_item(K_SERVICE, 8'h00, 32'd0));
        end
    endtask

    task automatic test_unused_kind();
        begin
            send_item(make_item(K_UNUSED, 8'hC3, 32'h8000_0001));
        end
    endtask

    task automatic test_queue_full();
        int i;
        begin
            for (i = 0; i < SLOTS - 1; i++)
                send_item(make_item(K_ADD, 8'(i * 17 + 1), 32'd0));
            send_item(make_item(K_ADD, 8'h99, 32'd0));
        end
    endtask

    task automatic test_service_limit();
        begin
            write_service_limit(5'd0);
            send_item(make_item(K_SERVICE, 8'h00, 32'd0));
            write_service_limit(5'd31);
            send_item(make_item(K_SERVICE, 8'h00, 32'd0));
        end
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input logic [CFG_W-1:0] limit);
        t_in_item it;
        int       sent;
        begin
            write_service_limit(limit);
            sender_idle_pct = idle_pct;
            sent = 0;
            while (sent < count) begin
                it = random_item();
                send_item(it);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        tick_now        = 64'd0;
        slot_count      = 0;
        service_limit   = SERVICE_RESET;
        error_count     = 0;
        stall_cycles    = 0;
        sender_idle_pct = 30;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_add_ordering();
        test_unused_kind();
        test_queue_full();
        test_service_limit();
        test_random_traffic(64, 30, 5'd1);
        test_random_traffic(64, 62, 5'd16);
        test_random_traffic(64, 0, 5'($urandom_range(31)));

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timer_queue.sv
bench/tb.sv
